// ===== rtl/wrfc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and register indexes of the weighted recency/frequency cache directory.
package wrfc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int REC_W   = $clog2(ENTRIES + 1);
    localparam int TAG_W   = 32;
    localparam int CNT_W   = 16;
    localparam int WT_W    = 8;
    localparam int SLOT_W  = 3;
    localparam int TOT_W   = 32;
    localparam int SCORE_W = WT_W + CNT_W + 1;
    localparam int CFG_IDX_W = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [REC_W-1:0] REC_TOP   = REC_W'(ENTRIES);
    localparam logic [TOT_W-1:0] HIT_COST  = TOT_W'(1);
    localparam logic [TOT_W-1:0] MISS_COST = TOT_W'(10);
    localparam logic [WT_W-1:0]  WT_RESET  = WT_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_FREQ_WEIGHT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RECENCY_WEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic has_free;
        logic scan_last;
    } dp_status_t;

endpackage

// ===== rtl/wrfc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the cache directory: lookup, victim scan, commit and result handshake.
module wrfc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  wrfc_pkg::dp_status_t   status,
    output wrfc_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (status.hit || status.has_free) begin
                    state_next = ST_COMMIT;
                end else begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold until the previous result beat has gone
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/wrfc_datapath.sv =====
`timescale 1ns / 1ps
// Entry store, tag compare, score scan, totals and result register of the cache directory.
module wrfc_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  wrfc_pkg::ctrl_cmd_t                  cmd,
    output wrfc_pkg::dp_status_t                 status,
    input  logic [wrfc_pkg::TAG_W-1:0]           s_access_address,
    input  logic                                 cfg_we,
    input  logic [wrfc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wrfc_pkg::WT_W-1:0]            cfg_data,
    output logic                                 m_hit,
    output logic [wrfc_pkg::SLOT_W-1:0]          m_slot,
    output logic                                 m_evicted,
    output logic [wrfc_pkg::TAG_W-1:0]           m_evicted_tag,
    output logic [wrfc_pkg::TOT_W-1:0]           m_hit_total,
    output logic [wrfc_pkg::TOT_W-1:0]           m_miss_total,
    output logic [wrfc_pkg::TOT_W-1:0]           m_elapsed_time
);

    localparam int N = wrfc_pkg::ENTRIES;

    logic [wrfc_pkg::TAG_W-1:0]   addr_reg;
    logic [N-1:0]                 valid_reg;
    logic [wrfc_pkg::TAG_W-1:0]   tag_reg [N];
    logic [wrfc_pkg::CNT_W-1:0]   cnt_reg [N];
    logic [wrfc_pkg::REC_W-1:0]   rec_reg [N];
    logic [wrfc_pkg::WT_W-1:0]    freq_wt_reg, rec_wt_reg;
    logic [wrfc_pkg::IDX_W-1:0]   scan_idx_reg, best_idx_reg;
    logic [wrfc_pkg::SCORE_W-1:0] best_score_reg;
    logic [wrfc_pkg::TOT_W-1:0]   hit_cnt_reg, miss_cnt_reg, time_cnt_reg;
    logic                         out_hit_reg, out_evicted_reg;
    logic [wrfc_pkg::SLOT_W-1:0]  out_slot_reg;
    logic [wrfc_pkg::TAG_W-1:0]   out_evicted_tag_reg;

    logic                             hit_found, free_found;
    logic [wrfc_pkg::IDX_W-1:0]       hit_idx, free_idx, slot_sel;
    logic [wrfc_pkg::WT_W+wrfc_pkg::CNT_W-1:0] freq_term;
    logic [wrfc_pkg::WT_W+wrfc_pkg::REC_W-1:0] rec_term;
    logic [wrfc_pkg::SCORE_W-1:0]     cand_score;

    // lowest-numbered matching entry and lowest-numbered free entry
    always_comb begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = N - 1; k >= 0; k--) begin
            if (valid_reg[k] && (tag_reg[k] == addr_reg)) begin
                hit_found = 1'b1;
                hit_idx   = wrfc_pkg::IDX_W'(k);
            end
            if (!valid_reg[k]) begin
                free_found = 1'b1;
                free_idx   = wrfc_pkg::IDX_W'(k);
            end
        end
    end

    assign freq_term  = freq_wt_reg * cnt_reg[scan_idx_reg];
    assign rec_term   = rec_wt_reg * rec_reg[scan_idx_reg];
    assign cand_score = wrfc_pkg::SCORE_W'(freq_term) + wrfc_pkg::SCORE_W'(rec_term);

    assign slot_sel = hit_found ? hit_idx : (free_found ? free_idx : best_idx_reg);

    assign status.hit       = hit_found;
    assign status.has_free  = free_found;
    assign status.scan_last = (scan_idx_reg == wrfc_pkg::IDX_W'(N - 1));

    // control state: valid bits, weights, totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            freq_wt_reg  <= wrfc_pkg::WT_RESET;
            rec_wt_reg   <= wrfc_pkg::WT_RESET;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            time_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    wrfc_pkg::REG_FREQ_WEIGHT:    freq_wt_reg <= cfg_data;
                    wrfc_pkg::REG_RECENCY_WEIGHT: rec_wt_reg  <= cfg_data;
                    default: ;  // drop writes to unknown registers
                endcase
            end
            if (cmd.commit) begin
                if (hit_found) begin
                    hit_cnt_reg  <= hit_cnt_reg + wrfc_pkg::TOT_W'(1);
                    time_cnt_reg <= time_cnt_reg + wrfc_pkg::HIT_COST;
                end else begin
                    valid_reg[slot_sel] <= 1'b1;
                    miss_cnt_reg <= miss_cnt_reg + wrfc_pkg::TOT_W'(1);
                    time_cnt_reg <= time_cnt_reg + wrfc_pkg::MISS_COST;
                end
            end
        end
    end

    // payload: entry fields, scan registers, result register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg <= s_access_address;
        end
        if (cmd.scan_clear) begin
            scan_idx_reg <= '0;
        end
        if (cmd.scan_step) begin
            // strict compare keeps the lowest index on equal scores
            if ((scan_idx_reg == '0) || (cand_score < best_score_reg)) begin
                best_score_reg <= cand_score;
                best_idx_reg   <= scan_idx_reg;
            end
            scan_idx_reg <= scan_idx_reg + wrfc_pkg::IDX_W'(1);
        end
        if (cmd.commit) begin
            out_hit_reg  <= hit_found;
            out_slot_reg <= wrfc_pkg::SLOT_W'(slot_sel);
            if (hit_found) begin
                out_evicted_reg     <= 1'b0;
                out_evicted_tag_reg <= '0;
                for (int k = 0; k < N; k++) begin
                    if (wrfc_pkg::IDX_W'(k) == hit_idx) begin
                        if (cnt_reg[k] != wrfc_pkg::COUNT_MAX) begin
                            cnt_reg[k] <= cnt_reg[k] + wrfc_pkg::CNT_W'(1);
                        end
                        rec_reg[k] <= wrfc_pkg::REC_TOP;
                    end else if (valid_reg[k] && (rec_reg[k] != '0)) begin
                        rec_reg[k] <= rec_reg[k] - wrfc_pkg::REC_W'(1);
                    end
                end
            end else begin
                out_evicted_reg     <= !free_found;
                out_evicted_tag_reg <= free_found ? '0 : tag_reg[best_idx_reg];
                tag_reg[slot_sel]   <= addr_reg;
                cnt_reg[slot_sel]   <= wrfc_pkg::CNT_W'(1);
                rec_reg[slot_sel]   <= wrfc_pkg::REC_TOP;
            end
        end
    end

    assign m_hit          = out_hit_reg;
    assign m_slot         = out_slot_reg;
    assign m_evicted      = out_evicted_reg;
    assign m_evicted_tag  = out_evicted_tag_reg;
    // totals move only at commit, which waits for the previous beat to go
    assign m_hit_total    = hit_cnt_reg;
    assign m_miss_total   = miss_cnt_reg;
    assign m_elapsed_time = time_cnt_reg;

endmodule

// ===== rtl/weighted_recency_frequency_cache_top.sv =====
`timescale 1ns / 1ps
// Top level of the weighted recency/frequency replacement cache directory.
//
// Fully associative directory of eight tags. Each beat on the s_ channel carries
// one access address; each beat on the m_ channel carries one result: hit flag,
// slot, eviction flag and tag, and the running hit, miss and cost totals.
// The cfg channel writes freq_weight (index 0) and recency_weight (index 1);
// it is always ready and should be used only while no access is in flight.
// An accepted access is looked up; on a hit or when a free entry exists it goes
// straight to commit and the result beat. Otherwise a victim must be chosen
// first: the victim scan scores one entry per cycle through a single score unit
// (two multiplies and an add) before the commit.
// One access is in flight at a time; s_ready is high only while the sequencer
// is idle, and the next address is taken while a result still waits on m_.
// A stalled result (m_ready low) holds its payload and blocks the commit of the
// following access until the beat goes.
// Reset (aresetn low, synchronous) empties every entry, clears the totals and
// sets both weights to 1; no clearing pass is needed.
module weighted_recency_frequency_cache_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [wrfc_pkg::TAG_W-1:0]         s_access_address,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic [wrfc_pkg::SLOT_W-1:0]        m_slot,
    output logic                               m_evicted,
    output logic [wrfc_pkg::TAG_W-1:0]         m_evicted_tag,
    output logic [wrfc_pkg::TOT_W-1:0]         m_hit_total,
    output logic [wrfc_pkg::TOT_W-1:0]         m_miss_total,
    output logic [wrfc_pkg::TOT_W-1:0]         m_elapsed_time,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wrfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wrfc_pkg::WT_W-1:0]          cfg_data
);

    wrfc_pkg::ctrl_cmd_t  cmd;
    wrfc_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    wrfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wrfc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_access_address (s_access_address),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_hit            (m_hit),
        .m_slot           (m_slot),
        .m_evicted        (m_evicted),
        .m_evicted_tag    (m_evicted_tag),
        .m_hit_total      (m_hit_total),
        .m_miss_total     (m_miss_total),
        .m_elapsed_time   (m_elapsed_time)
    );

endmodule

// ===== rtl/wrfc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the cache directory and their binding to the top level.
module wrfc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_hit,
    input logic [wrfc_pkg::SLOT_W-1:0]        m_slot,
    input logic                               m_evicted,
    input logic [wrfc_pkg::TAG_W-1:0]         m_evicted_tag,
    input logic [wrfc_pkg::TOT_W-1:0]         m_hit_total,
    input logic [wrfc_pkg::TOT_W-1:0]         m_miss_total,
    input logic [wrfc_pkg::TOT_W-1:0]         m_elapsed_time
);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_slot)
            && $stable(m_evicted) && $stable(m_evicted_tag) && $stable(m_hit_total)
            && $stable(m_miss_total) && $stable(m_elapsed_time))
        else $error("result beat changed while stalled");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> !m_evicted)
        else $error("eviction reported on a hit");

    a_evict_tag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted |-> m_evicted_tag == '0)
        else $error("evicted tag not zero without eviction");

    a_cost_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_elapsed_time == m_hit_total + wrfc_pkg::TOT_W'(m_miss_total * wrfc_pkg::MISS_COST))
        else $error("elapsed time out of step with hit and miss totals");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second access taken while one is in flight");

endmodule

bind weighted_recency_frequency_cache_top wrfc_checker u_wrfc_checker (.*);

// ===== verif/weighted_recency_frequency_cache_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the weighted recency/frequency cache directory top level.
module weighted_recency_frequency_cache_top_tb;
    import wrfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;
    localparam int CHUNKS         = 12;
    localparam int CHUNK_ITEMS    = 100;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [TAG_W-1:0]  evicted_tag;
        logic [TOT_W-1:0]  hit_total;
        logic [TOT_W-1:0]  miss_total;
        logic [TOT_W-1:0]  elapsed_time;
    } lookup_result_t;

    class lookup_scoreboard;
        logic [WT_W-1:0]  freq_w;
        logic [WT_W-1:0]  rec_w;
        bit               line_valid [ENTRIES];
        logic [TAG_W-1:0] line_tag   [ENTRIES];
        logic [CNT_W-1:0] line_count [ENTRIES];
        logic [REC_W-1:0] line_age   [ENTRIES];
        logic [TOT_W-1:0] hits;
        logic [TOT_W-1:0] misses;
        logic [TOT_W-1:0] cost;
        lookup_result_t   expected_lookups [$];
        int               mismatches;

        function new();
            freq_w = WT_RESET;
            rec_w  = WT_RESET;
            for (int k = 0; k < ENTRIES; k++) begin
                line_valid[k] = 1'b0;
                line_tag[k]   = '0;
                line_count[k] = '0;
                line_age[k]   = '0;
            end
            hits       = '0;
            misses     = '0;
            cost       = '0;
            mismatches = 0;
        endfunction

        function void write_weight(logic [CFG_IDX_W-1:0] idx, logic [WT_W-1:0] data);
            if (idx == REG_FREQ_WEIGHT)
                freq_w = data;
            else if (idx == REG_RECENCY_WEIGHT)
                rec_w = data;
        endfunction

        function int unsigned line_score(int k);
            int unsigned f, c, r, a;
            f = freq_w;
            c = line_count[k];
            r = rec_w;
            a = line_age[k];
            return f * c + r * a;
        endfunction

        function lookup_result_t predict_lookup(logic [TAG_W-1:0] addr);
            lookup_result_t res;
            int             found;
            int             victim;
            int unsigned    best;
            int unsigned    s;
            res   = '0;
            found = -1;
            for (int k = 0; k < ENTRIES; k++)
                if (found < 0 && line_valid[k] && line_tag[k] == addr)
                    found = k;
            if (found >= 0) begin
                res.hit  = 1'b1;
                res.slot = SLOT_W'(found);
                if (line_count[found] != COUNT_MAX)
                    line_count[found] = line_count[found] + 1'b1;
                line_age[found] = REC_TOP;
                // age every other live entry, floored at zero
                for (int k = 0; k < ENTRIES; k++)
                    if (k != found && line_valid[k] && line_age[k] != '0)
                        line_age[k] = line_age[k] - 1'b1;
                hits = hits + 1'b1;
                cost = cost + HIT_COST;
            end else begin
                victim = -1;
                for (int k = 0; k < ENTRIES; k++)
                    if (victim < 0 && !line_valid[k])
                        victim = k;
                if (victim < 0) begin
                    // strict less-than keeps the lowest index on a tie
                    victim = 0;
                    best   = line_score(0);
                    for (int k = 1; k < ENTRIES; k++) begin
                        s = line_score(k);
                        if (s < best) begin
                            best   = s;
                            victim = k;
                        end
                    end
                    res.evicted     = 1'b1;
                    res.evicted_tag = line_tag[victim];
                end
                res.slot           = SLOT_W'(victim);
                line_valid[victim] = 1'b1;
                line_tag[victim]   = addr;
                line_count[victim] = CNT_W'(1);
                line_age[victim]   = REC_TOP;
                misses = misses + 1'b1;
                cost   = cost + MISS_COST;
            end
            res.hit_total    = hits;
            res.miss_total   = misses;
            res.elapsed_time = cost;
            return res;
        endfunction

        function void note_access(logic [TAG_W-1:0] addr);
            lookup_result_t want;
            want = predict_lookup(addr);
            expected_lookups.insert(expected_lookups.size(), want);
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

        task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
            mismatches++;
        endtask

        task check_result(lookup_result_t got);
            lookup_result_t want;
            if (expected_lookups.size() == 0) begin
                report_mismatch("result beat with no access outstanding", 0, 0);
                return;
            end
            want = expected_lookups.pop_front();
            if (got.hit != want.hit)
                report_mismatch("hit", want.hit, got.hit);
            if (got.slot != want.slot)
                report_mismatch("slot", want.slot, got.slot);
            if (got.evicted != want.evicted)
                report_mismatch("evicted", want.evicted, got.evicted);
            if (got.evicted_tag != want.evicted_tag)
                report_mismatch("evicted_tag", want.evicted_tag, got.evicted_tag);
            if (got.hit_total != want.hit_total)
                report_mismatch("hit_total", want.hit_total, got.hit_total);
            if (got.miss_total != want.miss_total)
                report_mismatch("miss_total", want.miss_total, got.miss_total);
            if (got.elapsed_time != want.elapsed_time)
                report_mismatch("elapsed_time", want.elapsed_time, got.elapsed_time);
        endtask
    endclass

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [TAG_W-1:0]     s_access_address = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic                 m_hit;
    logic [SLOT_W-1:0]    m_slot;
    logic                 m_evicted;
    logic [TAG_W-1:0]     m_evicted_tag;
    logic [TOT_W-1:0]     m_hit_total;
    logic [TOT_W-1:0]     m_miss_total;
    logic [TOT_W-1:0]     m_elapsed_time;
    logic                 cfg_valid        = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    logic [WT_W-1:0]      cfg_data         = '0;

    lookup_scoreboard sb;
    bit               idle_on     = 1'b0;
    int               ready_hold  = 0;
    int               quiet_count = 0;

    weighted_recency_frequency_cache_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_access_address (s_access_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_slot           (m_slot),
        .m_evicted        (m_evicted),
        .m_evicted_tag    (m_evicted_tag),
        .m_hit_total      (m_hit_total),
        .m_miss_total     (m_miss_total),
        .m_elapsed_time   (m_elapsed_time),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result-side back-pressure in bursts, only while idle_on is set
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 9);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_weight(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.note_access(s_access_address);
            if (m_valid && m_ready)
                sb.check_result({m_hit, m_slot, m_evicted, m_evicted_tag,
                                 m_hit_total, m_miss_total, m_elapsed_time});
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_access(input logic [TAG_W-1:0] addr);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 10);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_access_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // hold the sender until every outstanding access has returned its beat
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic set_weights(input logic [WT_W-1:0] fw, input logic [WT_W-1:0] rw,
                               input bit stray, input logic [CFG_IDX_W-1:0] stray_idx);
        write_reg(REG_FREQ_WEIGHT, fw);
        write_reg(REG_RECENCY_WEIGHT, rw);
        if (stray)
            write_reg(stray_idx, WT_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [WT_W-1:0] pick_weight();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return WT_W'(1);
            default: return WT_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [TAG_W-1:0] pool [16];
        logic [TAG_W-1:0] addr;
        int               pool_size;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill every entry under reset weights, one hit on the way, then evict
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0000);
        send_access(32'h8000_0000);
        send_access(32'h0000_0001);
        send_access(32'h7FFF_FFFF);
        send_access(32'hAAAA_AAAA);
        send_access(32'h5555_5555);
        send_access(32'h1234_5678);
        send_access(32'hDEAD_BEEF);
        wait_for_results();

        // zero weights: all scores tie, so entry 0 goes; stray index must be ignored
        set_weights('0, '0, 1'b1, CFG_IDX_W'(2));
        send_access(32'hCAFE_F00D);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0F0F_0F0F);
        wait_for_results();

        // frequency only, then recency only, then both at full scale
        set_weights('1, '0, 1'b1, '1);
        send_access(32'h5555_5555);
        send_access(32'h5555_5555);
        send_access(32'hAAAA_AAAA);
        send_access(32'h3C3C_3C3C);
        wait_for_results();
        set_weights('0, '1, 1'b0, '0);
        send_access(32'h7FFF_FFFF);
        send_access(32'h8000_0000);
        send_access(32'hC3C3_C3C3);
        wait_for_results();
        set_weights('1, '1, 1'b0, '0);
        send_access(32'h0000_0002);
        send_access(32'hFFFF_FFFE);
        wait_for_results();

        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            set_weights(pick_weight(), pick_weight(), $urandom_range(0, 3) == 0,
                        CFG_IDX_W'($urandom_range(2, 255)));
            idle_on   <= (chunk < CHUNKS - 2) && (chunk % 4 != 3);
            pool_size = $urandom_range(9, 16);
            for (int p = 0; p < 16; p++)
                pool[p] = (p == 0) ? '0 : (p == 1) ? '1 : $urandom;
            for (int i = 0; i < CHUNK_ITEMS; i++) begin
                // a small working set keeps hits and evictions in the mix
                if ($urandom_range(0, 99) < 85)
                    addr = pool[$urandom_range(0, pool_size - 1)];
                else
                    addr = $urandom;
                send_access(addr);
                if (i == CHUNK_ITEMS / 2 && (chunk == 0 || $urandom_range(0, 2) == 0))
                    wait_for_results();
            end
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch("accesses left without a result", sb.pending(), 0);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
